// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the key LED color engine. Each checks on the rising
// edge of clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge.
`define KLCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("klce assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define KLCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error("klce assertion failed");
`else
`define KLCE_ASSERT(lbl, prop)
`define KLCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/klce_pkg.sv
// ----------------------------------------------------------------------------
// klce_pkg
// Shared types and constants of the key LED color engine.
// ----------------------------------------------------------------------------
package klce_pkg;

  localparam int KLCE_MAX_KEYS = 128;

  // Step counter shared by the divider and the pulse multiplier.
  localparam int STEP_W     = 3;
  localparam int DIV_STEPS  = 8;
  localparam int MULT_STEPS = 4;
  localparam logic [STEP_W-1:0] DIV_LAST  = 3'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] MULT_LAST = 3'(MULT_STEPS - 1);

  typedef enum logic [1:0] {
    OP_RENDER  = 2'd0,
    OP_WRITE   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_CONFIGURED   = 2'd0,
    CFG_OVERRIDE     = 2'd1,
    CFG_BUTTON_COUNT = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    MODE_FIXED = 2'd0,
    MODE_WHEEL = 2'd1,
    MODE_PULSE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_RENDER = 3'd1,
    ST_DIVIDE = 3'd2,
    ST_WHEEL  = 3'd3,
    ST_MULT   = 3'd4,
    ST_DONE   = 3'd5
  } state_e;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] key_index;
    logic       pressed;
    logic       click_valid;
    logic [7:0] click_red;
    logic [7:0] click_green;
    logic [7:0] click_blue;
    logic       anim_valid;
    logic [7:0] anim_kind;
    logic [7:0] anim_red;
    logic [7:0] anim_green;
    logic [7:0] anim_blue;
  } in_item_t;

  typedef struct packed {
    logic [6:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic              load;
    logic              write;
    logic              advance;
    logic              start;
    logic              div_step;
    logic              mult_step;
    logic              wheel;
    logic              emit;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic  render_hit;
    logic  write_hit;
    logic  advance;
    mode_e mode;
    logic  out_free;
  } sts_t;

endpackage

// File: rtl/klce_ctrl.sv
// ----------------------------------------------------------------------------
// klce_ctrl
// Sequencer of the key LED color engine: accepts beats and steps the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module klce_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  klce_pkg::sts_t sts_i,
  output klce_pkg::cmd_t cmd_o
);
  import klce_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    cmd_o    = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load    = in_valid_i;
        cmd_o.write   = in_valid_i && sts_i.write_hit;
        cmd_o.advance = in_valid_i && sts_i.advance;
        if (in_valid_i && sts_i.render_hit) begin
          state_d = ST_RENDER;
        end
      end
      ST_RENDER: begin
        cmd_o.start = 1'b1;
        step_d      = '0;
        unique case (sts_i.mode)
          MODE_WHEEL: state_d = ST_DIVIDE;
          MODE_PULSE: state_d = ST_MULT;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 3'd1;
        if (step_q == DIV_LAST) begin
          state_d = ST_WHEEL;
        end
      end
      ST_WHEEL: begin
        cmd_o.wheel = 1'b1;
        state_d     = ST_DONE;
      end
      ST_MULT: begin
        cmd_o.mult_step = 1'b1;
        step_d          = step_q + 3'd1;
        if (step_q == MULT_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `KLCE_ASSERT_NEXT(a_hit_to_render, in_valid_i && !in_stall_o && sts_i.render_hit, state_q == ST_RENDER)
  `KLCE_ASSERT_NEXT(a_div_to_wheel, state_q == ST_DIVIDE && step_q == DIV_LAST, state_q == ST_WHEEL)
  `KLCE_ASSERT_NEXT(a_mult_to_done, state_q == ST_MULT && step_q == MULT_LAST, state_q == ST_DONE)

endmodule

// File: rtl/klce_dpath.sv
// ----------------------------------------------------------------------------
// klce_dpath
// Datapath of the key LED color engine: key tables, frame counter, offset
// divider, pulse scaler and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module klce_dpath #(
  parameter int MAX_KEYS = klce_pkg::KLCE_MAX_KEYS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  klce_pkg::in_item_t in_data_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  klce_pkg::cmd_t     cmd_i,
  output klce_pkg::sts_t     sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output klce_pkg::out_item_t out_data_o
);
  import klce_pkg::*;

  localparam int         AddrW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam logic [7:0] MaxCount = 8'(MAX_KEYS);
  localparam logic [7:0] KindWheel  = 8'd0;
  localparam logic [7:0] KindPulse  = 8'd1;
  localparam logic [7:0] KindStill  = 8'd2;
  localparam logic [7:0] PulseFloor = 8'd20;
  localparam logic [7:0] WheelSeg1  = 8'd85;
  localparam logic [7:0] WheelSeg2  = 8'd170;
  localparam logic [7:0] Full       = 8'hFF;

  // Floor of x/255 for x up to 255*255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  // Color wheel: red to blue to green to red.
  function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
    logic [7:0] p;
    logic [9:0] p3;
    logic [7:0] up;
    logic [7:0] dn;
    if (pos < WheelSeg1) begin
      p = pos;
    end else if (pos < WheelSeg2) begin
      p = pos - WheelSeg1;
    end else begin
      p = pos - WheelSeg2;
    end
    p3 = {2'b00, p} + {1'b0, p, 1'b0};
    up = p3[7:0];
    dn = Full - up;
    if (pos < WheelSeg1) begin
      return {dn, 8'd0, up};
    end else if (pos < WheelSeg2) begin
      return {8'd0, up, dn};
    end
    return {up, dn, 8'd0};
  endfunction

  // Configuration.
  logic       configured_q;
  logic       override_q;
  logic [7:0] count_q;
  logic [7:0] cnt_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      configured_q <= 1'b0;
      override_q   <= 1'b0;
      count_q      <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CONFIGURED:   configured_q <= cfg_data_i[0];
        CFG_OVERRIDE:     override_q   <= cfg_data_i[0];
        CFG_BUTTON_COUNT: count_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cnt_eff = (count_q > MaxCount) ? MaxCount : count_q;

  // Beat decode.
  logic             in_range;
  logic [AddrW-1:0] addr;

  assign in_range = ({1'b0, in_data_i.key_index} < cnt_eff);
  assign addr     = in_data_i.key_index[AddrW-1:0];

  always_comb begin
    sts_o            = '0;
    sts_o.render_hit = (in_data_i.op == OP_RENDER) && in_range;
    sts_o.write_hit  = (in_data_i.op == OP_WRITE) && in_range;
    sts_o.advance    = (in_data_i.op == OP_ADVANCE);
    sts_o.out_free   = !out_valid_o || !out_stall_i;
    sts_o.mode       = MODE_FIXED;
    sts_o.mode       = mode;
  end

  // Key tables: payload in memory, valid bits in flops.
  logic [23:0] click_mem [MAX_KEYS];
  logic [31:0] anim_mem  [MAX_KEYS];
  logic        click_vld_q [MAX_KEYS];
  logic        anim_vld_q  [MAX_KEYS];
  logic [23:0] click_rd_q;
  logic [31:0] anim_rd_q;
  logic        click_vld_rd_q;
  logic        anim_vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      click_mem[addr] <= {in_data_i.click_red, in_data_i.click_green, in_data_i.click_blue};
      anim_mem[addr]  <= {in_data_i.anim_kind, in_data_i.anim_red,
                          in_data_i.anim_green, in_data_i.anim_blue};
    end
    if (cmd_i.load && in_range) begin
      click_rd_q <= click_mem[addr];
      anim_rd_q  <= anim_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_KEYS; i++) begin
        click_vld_q[i] <= 1'b0;
        anim_vld_q[i]  <= 1'b0;
      end
      click_vld_rd_q <= 1'b0;
      anim_vld_rd_q  <= 1'b0;
    end else begin
      if (cmd_i.write) begin
        click_vld_q[addr] <= in_data_i.click_valid;
        anim_vld_q[addr]  <= in_data_i.anim_valid;
      end
      if (cmd_i.load && in_range) begin
        click_vld_rd_q <= click_vld_q[addr];
        anim_vld_rd_q  <= anim_vld_q[addr];
      end
    end
  end

  // Item and frame counter.
  logic [6:0]  idx_q;
  logic        pressed_q;
  logic [15:0] frame_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q     <= in_data_i.key_index;
      pressed_q <= in_data_i.pressed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (cmd_i.advance) begin
      frame_q <= frame_q + 16'd1;
    end
  end

  // Color selection.
  mode_e       mode;
  logic [23:0] fixed_rgb;
  logic        cfg_ovr;

  assign cfg_ovr = configured_q && override_q;

  always_comb begin
    mode      = MODE_FIXED;
    fixed_rgb = {Full, 8'd0, 8'd0};
    if (pressed_q) begin
      if (cfg_ovr) begin
        fixed_rgb = {8'd0, 8'd0, Full};
      end else if (configured_q && click_vld_rd_q) begin
        fixed_rgb = click_rd_q;
      end else begin
        fixed_rgb = {8'd0, Full, 8'd0};
      end
    end else if (cfg_ovr) begin
      fixed_rgb = {Full, Full, Full};
    end else if (configured_q && anim_vld_rd_q) begin
      unique case (anim_rd_q[31:24])
        KindWheel: mode = MODE_WHEEL;
        KindPulse: mode = MODE_PULSE;
        KindStill: fixed_rgb = anim_rd_q[23:0];
        default: ;
      endcase
    end
  end

  // Offset divider: idx*256/count, one quotient bit a step.
  logic [6:0] rem_q;
  logic [7:0] quo_q;
  logic [7:0] shifted;
  logic [7:0] diff;
  logic       ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = (shifted >= cnt_eff);
  assign diff    = shifted - cnt_eff;

  // Pulse level and scaling.
  logic [7:0]       lvl_raw;
  logic [7:0]       level;
  logic [2:0][7:0]  base;
  logic [1:0]       mul_sel;
  logic [1:0]       wr_sel;
  logic [15:0]      prod_q;
  logic [2:0][7:0]  col_q;
  logic [7:0]       wheel_pos;

  assign lvl_raw   = frame_q[10] ? ~frame_q[9:2] : frame_q[9:2];
  assign level     = (lvl_raw < PulseFloor) ? PulseFloor : lvl_raw;
  assign base      = anim_rd_q[23:0];
  assign mul_sel   = 2'(3'd2 - cmd_i.step);
  assign wr_sel    = 2'(3'd3 - cmd_i.step);
  assign wheel_pos = ~(quo_q + frame_q[9:2]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      col_q <= fixed_rgb;
      rem_q <= idx_q;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[6:0] : shifted[6:0];
      quo_q <= {quo_q[6:0], ge};
    end
    if (cmd_i.wheel) begin
      col_q <= wheel_rgb(wheel_pos);
    end
    if (cmd_i.mult_step) begin
      if (cmd_i.step < MULT_LAST) begin
        prod_q <= base[mul_sel] * level;
      end
      if (cmd_i.step != '0) begin
        col_q[wr_sel] <= div255(prod_q);
      end
    end
  end

  // Output register.
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= {idx_q, col_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KLCE_ASSERT(a_rem_below_count, cmd_i.div_step |-> (8'(rem_q) < cnt_eff))
  `KLCE_ASSERT(a_emit_when_free, cmd_i.emit |-> sts_o.out_free)
  `KLCE_ASSERT_NEXT(a_advance_frame, cmd_i.advance, frame_q == $past(frame_q) + 16'd1)

endmodule

// File: rtl/key_led_color_engine.sv
// ----------------------------------------------------------------------------
// key_led_color_engine
// Renders the RGB drive value of one key LED per render beat.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i): one beat carries an
//    op. Render produces one output beat for a key below the effective count;
//    write stores the key's click color and idle animation; advance steps the
//    16-bit frame counter. Out-of-range keys and the unused op are dropped.
//  - Output channel (out_valid_o / out_stall_i / out_data_o): pixel index and
//    color, held in an output register until taken.
//  - Configuration port: cfg_we_i writes cfg_index_i (configured, override,
//    button count) with cfg_data_i; write only while the block is idle.
//  - Sequencing: write, advance and dropped beats are taken in the idle state
//    and leave the input free. A render stalls the input until its result is
//    emitted; a pulse uses three 8x8 multiplies through one multiplier and the
//    color wheel an 8-step offset divider.
//  - A finished result waits in the output register; the next beat is taken
//    while it waits, and a second result stalls in the sequencer until the
//    register frees up.
//  - Reset restores configuration defaults and clears the frame counter, table
//    valid bits and output valid flag at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_led_color_engine #(
  parameter int MAX_KEYS = klce_pkg::KLCE_MAX_KEYS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  klce_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output klce_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import klce_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: accept beats, step divider and multiplier, emit results.
  klce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: tables, frame counter, arithmetic and output register.
  klce_dpath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/sv/key_led_color_engine_tb.sv
// ----------------------------------------------------------------------------
// key_led_color_engine_tb
// Self-checking bench for the key LED color engine. A behavioral color
// predictor tracks the key tables, the frame counter and the configuration,
// and queues the pixel expected for every in-range render beat. A monitor
// checks each output beat against the oldest queued pixel, field by field.
// Directed tests cover reset defaults, the table contents, the key count
// limits and a full frame counter wrap. They are followed by a back-pressure
// test and random phases under several configurations, with random gaps on
// the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module key_led_color_engine_tb;
  import klce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes with no member in the package enums.
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] KIND_WHEEL = 8'd0;
  localparam logic [7:0] KIND_PULSE = 8'd1;
  localparam logic [7:0] KIND_STILL = 8'd2;

  localparam int NUM_KEYS     = KLCE_MAX_KEYS;
  localparam int DRAIN_CYCLES = 20;       // longest render is the color wheel
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_BEATS  = 150;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT connections
  // --------------------------------------------------------------------------
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_led_color_engine u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Color predictor state: a mirror of the key tables, the frame counter and
  // the configuration registers, updated on every accepted input beat.
  // --------------------------------------------------------------------------
  logic        click_ok    [NUM_KEYS];
  logic [23:0] click_rgb   [NUM_KEYS];
  logic        anim_ok     [NUM_KEYS];
  logic [7:0]  anim_kind_q [NUM_KEYS];
  logic [23:0] anim_rgb    [NUM_KEYS];
  logic [15:0] frame_q;
  logic        cfg_on;
  logic        cfg_ovr;
  logic [7:0]  cfg_count;

  out_item_t pixels_due [$];    // pixels owed by the DUT, oldest first

  int  beats_sent     = 0;
  int  pixels_checked = 0;
  int  mismatches     = 0;
  int  cycles         = 0;

  // Idling knobs, shared by the sender and the output stall process.
  bit  gaps_on   = 1'b1;
  bit  stalls_on = 1'b1;
  int  hold_left = 0;           // long receiver hold-off, in cycles
  int  stall_run = 0;

  // Key count as the DUT sees it: the register limited to the table depth.
  function automatic int live_keys();
    return (int'(cfg_count) > NUM_KEYS) ? NUM_KEYS : int'(cfg_count);
  endfunction

  // Color wheel: offset by the key's share of the ring plus a quarter of the
  // frame counter, then walk red -> blue -> green.
  function automatic logic [23:0] wheel_color(int idx, int cnt);
    int off;
    int pos;
    off = (idx * 256) / cnt;
    pos = 255 - ((off + int'(frame_q >> 2)) & 255);
    if (pos < 85) begin
      return {8'(255 - 3 * pos), 8'd0, 8'(3 * pos)};
    end else if (pos < 170) begin
      pos = pos - 85;
      return {8'd0, 8'(3 * pos), 8'(255 - 3 * pos)};
    end else begin
      pos = pos - 170;
      return {8'(3 * pos), 8'(255 - 3 * pos), 8'd0};
    end
  endfunction

  // Pulse: triangle brightness over 512 steps of four frames, floored at 20.
  function automatic logic [23:0] pulse_color(logic [23:0] base);
    int c;
    int lvl;
    c   = int'(frame_q >> 2);
    lvl = ((c % 512) < 256) ? (c & 255) : (255 - (c & 255));
    if (lvl < 20) lvl = 20;
    return {8'(int'(base[23:16]) * lvl / 255),
            8'(int'(base[15:8])  * lvl / 255),
            8'(int'(base[7:0])   * lvl / 255)};
  endfunction

  function automatic logic [23:0] key_color(int idx, logic pressed);
    if (pressed) begin
      if (cfg_on && cfg_ovr)            return 24'h0000FF;
      else if (cfg_on && click_ok[idx]) return click_rgb[idx];
      else                              return 24'h00FF00;
    end
    if (cfg_on && cfg_ovr) return 24'hFFFFFF;
    if (cfg_on && anim_ok[idx]) begin
      case (anim_kind_q[idx])
        KIND_WHEEL: return wheel_color(idx, live_keys());
        KIND_PULSE: return pulse_color(anim_rgb[idx]);
        KIND_STILL: return anim_rgb[idx];
        default:    return 24'hFF0000;
      endcase
    end
    return 24'hFF0000;
  endfunction

  // Apply one accepted beat to the mirror; queue a pixel for a render hit.
  function automatic void track_beat(in_item_t it);
    int        idx;
    out_item_t px;
    idx = int'(it.key_index);
    if (it.op == OP_ADVANCE) begin
      frame_q = frame_q + 16'd1;
      return;
    end
    if (it.op == OP_UNUSED || idx >= live_keys()) return;
    if (it.op == OP_WRITE) begin
      click_ok[idx]    = it.click_valid;
      click_rgb[idx]   = {it.click_red, it.click_green, it.click_blue};
      anim_ok[idx]     = it.anim_valid;
      anim_kind_q[idx] = it.anim_kind;
      anim_rgb[idx]    = {it.anim_red, it.anim_green, it.anim_blue};
      return;
    end
    px.pixel_index = it.key_index;
    {px.red, px.green, px.blue} = key_color(idx, it.pressed);
    pixels_due.push_back(px);
  endfunction

  // --------------------------------------------------------------------------
  // Beat builders. Fields that do not matter for the op stay random so that
  // every payload bit toggles.
  // --------------------------------------------------------------------------
  function automatic in_item_t noise_beat();
    logic [95:0] bits;
    bits = {$urandom(), $urandom(), $urandom()};
    return in_item_t'(bits[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t render_beat(int idx, logic pressed);
    in_item_t it;
    it           = noise_beat();
    it.op        = OP_RENDER;
    it.key_index = 7'(idx);
    it.pressed   = pressed;
    return it;
  endfunction

  function automatic in_item_t write_beat(int idx, logic cv, logic [23:0] crgb,
                                          logic av, logic [7:0] kind,
                                          logic [23:0] argb);
    in_item_t it;
    it           = noise_beat();
    it.op        = OP_WRITE;
    it.key_index = 7'(idx);
    it.click_valid = cv;
    {it.click_red, it.click_green, it.click_blue} = crgb;
    it.anim_valid  = av;
    it.anim_kind   = kind;
    {it.anim_red, it.anim_green, it.anim_blue} = argb;
    return it;
  endfunction

  function automatic in_item_t advance_beat();
    in_item_t it;
    it    = noise_beat();
    it.op = OP_ADVANCE;
    return it;
  endfunction

  // Idle gap after a beat: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one beat at the falling edge, hold it until taken, then
  // idle for a random gap. Valid stays high across back-to-back beats.
  // --------------------------------------------------------------------------
  task automatic send_beat(input in_item_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_beat(it);
    beats_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, wait for every owed pixel, then let a dropped or write beat
  // still in flight finish before anything touches the registers.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; call only after settle().
  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_CONFIGURED:   cfg_on    = val[0];
      CFG_OVERRIDE:     cfg_ovr   = val[0];
      CFG_BUTTON_COUNT: cfg_count = val;
      default: ;        // index past the register list is ignored
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls in runs, plus a long hold-off when a test
  // loads hold_left. The hold is counted down here at the falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!stalls_on) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
      stall_run <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 3);
    end
  end

  // Monitor: every output beat must match the oldest owed pixel.
  always @(posedge clk) begin
    out_item_t px;
    if (rst_n && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel beat: index %0d rgb %02h%02h%02h",
               out_data.pixel_index, out_data.red, out_data.green, out_data.blue);
        mismatches++;
      end else begin
        px = pixels_due.pop_front();
        pixels_checked++;
        if (out_data.pixel_index !== px.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", px.pixel_index,
                 out_data.pixel_index);
          mismatches++;
        end
        if (out_data.red !== px.red) begin
          $error("red: expected %0d, got %0d", px.red, out_data.red);
          mismatches++;
        end
        if (out_data.green !== px.green) begin
          $error("green: expected %0d, got %0d", px.green, out_data.green);
          mismatches++;
        end
        if (out_data.blue !== px.blue) begin
          $error("blue: expected %0d, got %0d", px.blue, out_data.blue);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still owed", cycles,
               pixels_due.size());
      $display("key_led_color_engine: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset state: one key, unconfigured, so pressed is green and released red.
  // Indices past the count and the unused op must drop silently.
  task automatic test_reset_defaults();
    in_item_t it;
    send_beat(render_beat(0, 1'b1));
    send_beat(render_beat(0, 1'b0));
    send_beat(render_beat(1, 1'b1));
    send_beat(render_beat(127, 1'b0));
    it    = noise_beat();
    it.op = OP_UNUSED;
    send_beat(it);
    // Entries stored while unconfigured must not show yet.
    send_beat(write_beat(0, 1'b1, 24'hFFFFFF, 1'b1, KIND_STILL, 24'hFFFFFF));
    send_beat(render_beat(0, 1'b1));
    send_beat(render_beat(0, 1'b0));
    settle();
  endtask

  // Table contents across the animation kinds and color extremes, then the
  // override mode with and without the configured flag.
  task automatic test_key_table();
    set_reg(CFG_BUTTON_COUNT, 8'd128);
    set_reg(CFG_CONFIGURED, 8'd1);
    send_beat(render_beat(5, 1'b1));      // empty entry: green
    send_beat(render_beat(5, 1'b0));      // empty entry: red
    send_beat(write_beat(0,   1'b1, 24'hFFFFFF, 1'b1, KIND_STILL, 24'h000000));
    send_beat(write_beat(127, 1'b1, 24'h000000, 1'b1, KIND_PULSE, 24'hFFFFFF));
    send_beat(write_beat(64,  1'b0, 24'h123456, 1'b1, 8'd3,       24'hABCDEF));
    send_beat(write_beat(1,   1'b1, 24'h5A5AA5, 1'b0, KIND_STILL, 24'h0F0F0F));
    send_beat(write_beat(2,   1'b0, 24'h000000, 1'b1, KIND_WHEEL, 24'h000000));
    send_beat(write_beat(3,   1'b1, 24'hC3C3C3, 1'b1, 8'd255,     24'h80FF01));
    for (int k = 0; k < 4; k++) begin
      send_beat(render_beat(k, 1'b1));
      send_beat(render_beat(k, 1'b0));
    end
    send_beat(render_beat(64, 1'b1));
    send_beat(render_beat(64, 1'b0));
    send_beat(render_beat(127, 1'b1));
    send_beat(render_beat(127, 1'b0));
    settle();
    set_reg(CFG_OVERRIDE, 8'd1);
    send_beat(render_beat(0, 1'b1));      // blue
    send_beat(render_beat(127, 1'b0));    // white
    settle();
    set_reg(CFG_CONFIGURED, 8'd0);        // override alone has no effect
    send_beat(render_beat(0, 1'b1));
    send_beat(render_beat(127, 1'b0));
    settle();
    set_reg(CFG_OVERRIDE, 8'd0);
    set_reg(CFG_CONFIGURED, 8'd1);
  endtask

  // Key count extremes: zero drops everything, counts past the table depth
  // clamp, a small count moves the wheel offset. The unused register index
  // must leave everything as it is.
  task automatic test_count_limits();
    set_reg(CFG_BUTTON_COUNT, 8'd0);
    send_beat(write_beat(0, 1'b1, 24'h010203, 1'b1, KIND_STILL, 24'h040506));
    send_beat(render_beat(0, 1'b1));
    send_beat(render_beat(0, 1'b0));
    settle();
    set_reg(CFG_BUTTON_COUNT, 8'd255);
    send_beat(render_beat(0, 1'b1));      // old entry, write above was dropped
    send_beat(write_beat(127, 1'b0, 24'h000000, 1'b1, KIND_WHEEL, 24'h000000));
    send_beat(render_beat(127, 1'b0));
    settle();
    set_reg(CFG_BUTTON_COUNT, 8'd3);
    send_beat(render_beat(2, 1'b0));
    send_beat(render_beat(3, 1'b0));      // dropped
    settle();
    set_reg(CFG_UNUSED, 8'hFF);
    send_beat(render_beat(2, 1'b0));
    settle();
    set_reg(CFG_BUTTON_COUNT, 8'd200);
    send_beat(render_beat(127, 1'b0));
    settle();
  endtask

  // Step the frame counter through a full wrap, sampling two pulse keys and a
  // wheel key at uneven points so both rising and falling pulse slopes show up.
  task automatic test_frame_wrap();
    set_reg(CFG_BUTTON_COUNT, 8'd128);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_beat(write_beat(10, 1'b0, 24'h000000, 1'b1, KIND_PULSE, 24'($urandom())));
    send_beat(write_beat(11, 1'b0, 24'h000000, 1'b1, KIND_WHEEL, 24'h000000));
    send_beat(write_beat(12, 1'b0, 24'h000000, 1'b1, KIND_PULSE, 24'hFFFFFF));
    for (int n = 0; n < 65536 + 600; n++) begin
      if (n % 997 == 0 || (n % 1024) < 2) begin
        send_beat(render_beat(10, 1'b0));
        send_beat(render_beat(11, 1'b0));
        send_beat(render_beat(12, 1'b0));
      end
      send_beat(advance_beat());
    end
    settle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Hold the output off for a long stretch while renders keep coming, so
  // the output register and the sequencer fill and the input stalls.
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    hold_left = 400;
    repeat (32) send_beat(render_beat($urandom_range(0, 127), 1'($urandom())));
    settle();
    gaps_on = 1'b1;
  endtask

  // Random phases, each under its own configuration. Most beats are renders
  // and writes to live keys; the rest are frame bursts and mostly dropped beats.
  task automatic test_random();
    int       counts [7] = '{1, 2, 5, 64, 127, 128, 255};
    int       cnt;
    int       r;
    int       burst;
    in_item_t it;
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_reg(CFG_BUTTON_COUNT, (p == RAND_PHASES - 1) ? 8'($urandom_range(1, 255))
                                                       : 8'(counts[p % 7]));
      set_reg(CFG_CONFIGURED, 8'($urandom_range(0, 99) < 85));
      set_reg(CFG_OVERRIDE, 8'($urandom_range(0, 99) < 20));
      // One phase runs flat out with no idling on either side.
      gaps_on   = (p != 3);
      stalls_on = (p != 3);
      cnt = live_keys();
      for (int i = 0; i < PHASE_BEATS; i++) begin
        r  = $urandom_range(0, 99);
        it = noise_beat();
        if (r < 45) begin
          it.op        = OP_RENDER;
          it.key_index = 7'($urandom_range(0, cnt - 1));
        end else if (r < 72) begin
          it.op         = OP_WRITE;
          it.key_index  = 7'($urandom_range(0, cnt - 1));
          it.anim_valid = ($urandom_range(0, 4) != 0);
          if ($urandom_range(0, 9) < 7) it.anim_kind = 8'($urandom_range(0, 2));
        end else if (r < 84) begin
          // Advance burst: mostly short, sometimes long enough to sweep the
          // pulse through a good part of its period.
          burst = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 1500)
                                               : $urandom_range(1, 40);
          repeat (burst - 1) send_beat(advance_beat());
          it = advance_beat();
        end else if (r < 95) begin
          it.op = $urandom_range(0, 1) ? OP_WRITE : OP_RENDER;
          if (cnt < NUM_KEYS) it.key_index = 7'($urandom_range(cnt, 127));
        end else begin
          it.op = OP_UNUSED;
        end
        send_beat(it);
      end
      settle();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      click_ok[k]    = 1'b0;
      click_rgb[k]   = '0;
      anim_ok[k]     = 1'b0;
      anim_kind_q[k] = '0;
      anim_rgb[k]    = '0;
    end
    frame_q   = '0;
    cfg_on    = 1'b0;
    cfg_ovr   = 1'b0;
    cfg_count = 8'd1;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_key_table();
    test_count_limits();
    test_frame_wrap();
    test_backpressure();
    test_random();
    settle();

    $display("covered %0d beats and %0d checked pixels: reset defaults, all animation",
             beats_sent, pixels_checked);
    $display("kinds, override, key counts 0/1/128/255, a frame wrap and a long output hold");
    if (mismatches == 0) begin
      $display("key_led_color_engine: match");
    end else begin
      $display("key_led_color_engine: mismatch");
    end
    $finish;
  end

endmodule

// File: key_led_color_engine.f
+incdir+rtl
rtl/klce_pkg.sv
rtl/klce_ctrl.sv
rtl/klce_dpath.sv
rtl/key_led_color_engine.sv
tb/sv/key_led_color_engine_tb.sv
